// ===== src/uart_response_keyword_wait_macros.svh =====
// ----------------------------------------------------------------------------
// uart_response_keyword_wait_macros.svh
// Assertion macros shared by the keyword wait block.
// ----------------------------------------------------------------------------
`ifndef UART_RESPONSE_KEYWORD_WAIT_MACROS_SVH
`define UART_RESPONSE_KEYWORD_WAIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define URKW_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define URKW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/urkw_pkg.sv =====
// ----------------------------------------------------------------------------
// urkw_pkg
// Types, codes and constants shared by the keyword wait block.
// ----------------------------------------------------------------------------
package urkw_pkg;

    // Defaults for the top-level parameters
    localparam int KEY_MAX_DEF     = 16;
    localparam int RX_CAPACITY_DEF = 512;

    // Fixed sizes
    localparam int KEY_BYTES    = 16;   // bytes held by the two keyword registers
    localparam int QUEUE_DEPTH  = 2;    // power of two, pointers wrap naturally
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int HELD_OUT_W   = 9;
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_WAITING = 2'd1,
        ST_FOUND   = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_KEYWORD_LOW    = 2'd0,
        REG_KEYWORD_HIGH   = 2'd1,
        REG_KEYWORD_LENGTH = 2'd2,
        REG_TIMEOUT_TICKS  = 2'd3
    } reg_index_t;

    // Classified command passed from front to back
    typedef enum logic [2:0] {
        CMD_START,
        CMD_BYTE,
        CMD_BYTE_ZERO,
        CMD_TICK,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] wait_status;
        logic [8:0] bytes_held;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] rx_byte;
    } cmd_t;

    typedef struct packed {
        logic [63:0] keyword_low;
        logic [63:0] keyword_high;
        logic [4:0]  keyword_length;
        logic [31:0] timeout_ticks;
    } cfg_t;

    // Keyword byte j, little-endian across the two registers
    function automatic logic [7:0] key_byte(input cfg_t cfg, input logic [3:0] j);
        logic [7:0] b;
        if (j[3])
            b = cfg.keyword_high[8 * j[2:0] +: 8];
        else
            b = cfg.keyword_low[8 * j[2:0] +: 8];
        return b;
    endfunction

endpackage

// ===== src/urkw_queue.sv =====
// ----------------------------------------------------------------------------
// urkw_queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module urkw_queue
    import urkw_pkg::*;
#(
    parameter int WIDTH = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // Status and beat qualifiers
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = CNT_W'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== src/urkw_front.sv =====
// ----------------------------------------------------------------------------
// urkw_front
// Accepts input beats, classifies them and queues the commands.
// ----------------------------------------------------------------------------
module urkw_front
    import urkw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_take
);

    cmd_t cmd_in;
    logic cmd_empty;

    // Classify operation; zero bytes get their own command
    always_comb
    begin
        cmd_in.rx_byte = item.rx_byte;
        unique case (item.operation)
            OP_START: cmd_in.kind = CMD_START;
            OP_BYTE:  cmd_in.kind = (item.rx_byte == 8'd0) ? CMD_BYTE_ZERO : CMD_BYTE;
            OP_TICK:  cmd_in.kind = CMD_TICK;
            OP_NOP:   cmd_in.kind = CMD_NOP;
        endcase
    end

    // Command queue between front and back
    urkw_queue #(
        .WIDTH ($bits(cmd_t))
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .wr_data (cmd_in),
        .pop     (cmd_take),
        .empty   (cmd_empty),
        .rd_data (cmd)
    );

    assign cmd_valid = !cmd_empty;

endmodule

// ===== src/urkw_back.sv =====
// ----------------------------------------------------------------------------
// urkw_back
// Executes commands: receive window, keyword match, tick timeout, counters.
// ----------------------------------------------------------------------------
module urkw_back
    import urkw_pkg::*;
#(
    parameter int KEY_MAX     = KEY_MAX_DEF,
    parameter int RX_CAPACITY = RX_CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_take,
    input  logic      res_full,
    output logic      res_push,
    output out_item_t res_data
);

    localparam int HELD_W = $clog2(RX_CAPACITY);
    localparam int KL_W   = $clog2(KEY_MAX + 1);
    localparam logic [HELD_W-1:0] HELD_MAX = HELD_W'(RX_CAPACITY - 1);

    logic [7:0]        window_reg [KEY_MAX];
    logic [7:0]        window_next [KEY_MAX];
    logic [7:0]        win_shift [KEY_MAX];
    logic [HELD_W-1:0] held_reg, held_next;
    logic [31:0]       elapsed_reg, elapsed_next;
    status_t           status_reg, status_next;
    logic              ended_reg, ended_next;

    logic [7:0]        kb [KEY_BYTES];
    logic [KL_W-1:0]   len_cap;
    logic [KL_W-1:0]   key_len;
    logic              match;
    logic              step;
    logic [HELD_W+HELD_OUT_W-1:0] held_ext;

    assign step = cmd_valid && !res_full;

    // Keyword bytes and effective length (first zero byte ends it)
    always_comb
    begin
        logic stop;
        stop = 1'b0;
        for (int j = 0; j < KEY_BYTES; j++)
            kb[j] = key_byte(cfg, 4'(j));
        len_cap = (cfg.keyword_length > 5'(KEY_MAX)) ? KL_W'(KEY_MAX)
                                                     : KL_W'(cfg.keyword_length);
        key_len = len_cap;
        for (int j = 0; j < KEY_MAX; j++)
        begin
            if (!stop && (KL_W'(j) < len_cap) && (kb[j] == 8'd0))
            begin
                key_len = KL_W'(j);
                stop    = 1'b1;
            end
        end
    end

    // Window after shifting in the current byte
    always_comb
    begin
        win_shift[0] = cmd.rx_byte;
        for (int i = 1; i < KEY_MAX; i++)
            win_shift[i] = window_reg[i-1];
    end

    // Newest byte sits at slot 0, so slot i pairs with keyword byte len-1-i
    always_comb
    begin
        logic [4:0] idx;
        idx   = '0;
        match = 1'b1;
        for (int i = 0; i < KEY_MAX; i++)
        begin
            if (5'(i) < 5'(key_len))
            begin
                idx = 5'(key_len) - 5'(i) - 5'd1;
                if (win_shift[i] != kb[idx[3:0]])
                    match = 1'b0;
            end
        end
    end

    // Next state
    always_comb
    begin
        window_next  = window_reg;
        held_next    = held_reg;
        elapsed_next = elapsed_reg;
        status_next  = status_reg;
        ended_next   = ended_reg;
        if (step)
        begin
            unique case (cmd.kind)
                CMD_START:
                begin
                    for (int i = 0; i < KEY_MAX; i++)
                        window_next[i] = '0;
                    held_next    = '0;
                    elapsed_next = '0;
                    ended_next   = 1'b0;
                    if (cfg.timeout_ticks == '0)
                        status_next = ST_TIMEOUT;
                    else if (key_len == '0)
                        status_next = ST_FOUND;
                    else
                        status_next = ST_WAITING;
                end
                CMD_BYTE:
                begin
                    if (held_reg < HELD_MAX)
                    begin
                        held_next = held_reg + 1'b1;
                        if (!ended_reg)
                        begin
                            window_next = win_shift;
                            if ((status_reg == ST_WAITING) && match)
                                status_next = ST_FOUND;
                        end
                    end
                end
                CMD_BYTE_ZERO:
                begin
                    if (held_reg < HELD_MAX)
                    begin
                        held_next  = held_reg + 1'b1;
                        ended_next = 1'b1;
                    end
                end
                CMD_TICK:
                begin
                    if (status_reg == ST_WAITING)
                    begin
                        if (elapsed_reg != '1)
                            elapsed_next = elapsed_reg + 32'd1;
                        if (elapsed_next >= cfg.timeout_ticks)
                            status_next = ST_TIMEOUT;
                    end
                end
                CMD_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Outputs: one result beat per executed command
    always_comb
    begin
        cmd_take             = step;
        res_push             = step;
        held_ext             = {{HELD_OUT_W{1'b0}}, held_next};
        res_data.wait_status = status_next;
        res_data.bytes_held  = held_ext[HELD_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_MAX; i++)
                window_reg[i] <= '0;
            held_reg    <= '0;
            elapsed_reg <= '0;
            status_reg  <= ST_IDLE;
            ended_reg   <= 1'b0;
        end
        else
        begin
            window_reg  <= window_next;
            held_reg    <= held_next;
            elapsed_reg <= elapsed_next;
            status_reg  <= status_next;
            ended_reg   <= ended_next;
        end
    end

endmodule

// ===== src/uart_response_keyword_wait.sv =====
// ----------------------------------------------------------------------------
// uart_response_keyword_wait
// Watches received bytes for a configured keyword, with a tick timeout.
//
//   channel   direction  handshake           payload
//   item      in         push / full         in_item_t  (operation, rx_byte)
//   result    out        pop / empty         out_item_t (wait_status, bytes_held)
//   config    in         cfg_write           cfg_index, cfg_data
//
// One item per cycle sustained while neither queue stalls; each command is
// executed by the back end's shift-and-compare step. An item's result passes
// through the command queue and then the result queue to the result ports. Both
// sides stall on their own through two-entry queues. Reset clears queues, state
// and registers at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "uart_response_keyword_wait_macros.svh"

module uart_response_keyword_wait
    import urkw_pkg::*;
#(
    parameter int KEY_MAX     = KEY_MAX_DEF,
    parameter int RX_CAPACITY = RX_CAPACITY_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  in_item_t               item,
    input  logic                   pop,
    output logic                   empty,
    output out_item_t              result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg_reg;
    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_take;
    logic      res_full;
    logic      res_push;
    out_item_t res_data;
    logic      start_take;
    logic      res_live;
    logic      res_found;
    logic      res_no_start;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keyword_low    <= '0;
            cfg_reg.keyword_high   <= '0;
            cfg_reg.keyword_length <= '0;
            cfg_reg.timeout_ticks  <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KEYWORD_LOW:    cfg_reg.keyword_low    <= cfg_data;
                REG_KEYWORD_HIGH:   cfg_reg.keyword_high   <= cfg_data;
                REG_KEYWORD_LENGTH: cfg_reg.keyword_length <= cfg_data[4:0];
                REG_TIMEOUT_TICKS:  cfg_reg.timeout_ticks  <= cfg_data[31:0];
            endcase
        end
    end

    // Front: accept and classify
    urkw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // Back: execute
    urkw_back #(
        .KEY_MAX     (KEY_MAX),
        .RX_CAPACITY (RX_CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // Result queue
    urkw_queue #(
        .WIDTH ($bits(out_item_t))
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .full    (res_full),
        .wr_data (res_data),
        .pop     (pop),
        .empty   (empty),
        .rd_data (result)
    );

    // Terms used by the checks
    assign start_take   = cmd_take && (cmd.kind == CMD_START);
    assign res_live     = res_push && (res_data.wait_status != ST_IDLE);
    assign res_found    = res_push && (res_data.wait_status == ST_FOUND);
    assign res_no_start = res_push && !start_take;

    // Checks
    `URKW_ASSERT_IMPL(a_res_no_overflow, res_push, !res_full, "result beat pushed into full queue")
    `URKW_ASSERT_NEXT(a_start_has_result, start_take, !empty, "start left no result")
    `URKW_ASSERT_IMPL(a_no_return_to_idle, res_push && $past(res_live), res_live, "back to idle")
    `URKW_ASSERT_IMPL(a_found_sticky, res_no_start && $past(res_found), res_found, "found lost")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the keyword wait block item by item against a behavioral model of
// the matcher kept inside this bench. Directed tests cover reset values,
// keyword hits, the end-of-text zero byte, zero and maximum timeouts, keywords
// cut short by a zero byte and the full receive store. A back-pressure test
// fills the block's queues, and random phases with fresh register settings
// then drive keyword runs, stray bytes, ticks and restarts with random gaps
// on both handshakes.
// ----------------------------------------------------------------------------
module testbench;
    import urkw_pkg::*;

    localparam int LIMIT_NS  = 2_000_000;
    localparam int STORE_MAX = RX_CAPACITY_DEF - 1;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    in_item_t               rx_item;
    logic                   pop;
    logic                   empty;
    out_item_t              report;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Matcher model: registers and state
    logic [63:0] kw_low;
    logic [63:0] kw_high;
    logic [4:0]  kw_len;
    logic [31:0] tmo_ticks;
    logic [7:0]  recent [KEY_BYTES];
    int          held;
    logic [31:0] elapsed;
    status_t     wstate;
    bit          text_done;

    out_item_t   pending_reports [$];
    int          mismatch_count;
    int          beats_sent;
    int          hold_cycles;
    int          stall_left;
    bit          steady;

    uart_response_keyword_wait u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (rx_item),
        .pop       (pop),
        .empty     (empty),
        .result    (report),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock, 2 ns period
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Keyword byte j, little-endian across the two registers
    function automatic logic [7:0] kw_byte(int j);
        if (j < 8)
            return kw_low[8 * j +: 8];
        return kw_high[8 * (j - 8) +: 8];
    endfunction

    // Bytes of the keyword in use: clamped to 16, cut at the first zero byte
    function automatic int active_len();
        int n;
        n = (kw_len > KEY_BYTES) ? KEY_BYTES : int'(kw_len);
        for (int j = 0; j < n; j++)
            if (kw_byte(j) == 8'h00)
                return j;
        return n;
    endfunction

    function automatic bit window_hit();
        int n;
        n = active_len();
        for (int j = 0; j < n; j++)
            if (recent[n - 1 - j] != kw_byte(j))
                return 1'b0;
        return 1'b1;
    endfunction

    // One item through the matcher model; returns the status beat it causes
    function automatic out_item_t step_watcher(op_t op, logic [7:0] b);
        out_item_t r;
        if (op == OP_START)
        begin
            foreach (recent[k])
                recent[k] = 8'h00;
            held      = 0;
            elapsed   = '0;
            text_done = 1'b0;
            if (tmo_ticks == 0)
                wstate = ST_TIMEOUT;
            else if (active_len() == 0)
                wstate = ST_FOUND;
            else
                wstate = ST_WAITING;
        end
        else if (op == OP_BYTE)
        begin
            // full store drops the byte without counting or matching it
            if (held < STORE_MAX)
            begin
                held++;
                if (b == 8'h00)
                    text_done = 1'b1;
                else if (!text_done)
                begin
                    for (int k = KEY_BYTES - 1; k > 0; k--)
                        recent[k] = recent[k - 1];
                    recent[0] = b;
                    if (wstate == ST_WAITING && window_hit())
                        wstate = ST_FOUND;
                end
            end
        end
        else if (op == OP_TICK)
        begin
            if (wstate == ST_WAITING)
            begin
                if (elapsed != 32'hFFFF_FFFF)
                    elapsed++;
                if (elapsed >= tmo_ticks)
                    wstate = ST_TIMEOUT;
            end
        end
        r.wait_status = wstate;
        r.bytes_held  = held[8:0];
        return r;
    endfunction

    // Sender gaps: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one item beat and record the status it must produce
    task automatic send_item(op_t op, logic [7:0] b);
        int gap;
        @(negedge clk);
        push              = 1'b1;
        rx_item.operation = op;
        rx_item.rx_byte   = b;
        do
            @(posedge clk);
        while (full);
        pending_reports.push_back(step_watcher(op, b));
        beats_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            push = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Wait for every status beat to come back, then past the pipeline
    task automatic settle();
        @(negedge clk);
        push = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [63:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            REG_KEYWORD_LOW:    kw_low    = value;
            REG_KEYWORD_HIGH:   kw_high   = value;
            REG_KEYWORD_LENGTH: kw_len    = value[4:0];
            REG_TIMEOUT_TICKS:  tmo_ticks = value[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_keyword(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
                               logic [31:0] ticks);
        settle();
        write_reg(REG_KEYWORD_LOW, lo);
        write_reg(REG_KEYWORD_HIGH, hi);
        write_reg(REG_KEYWORD_LENGTH, {59'd0, len});
        write_reg(REG_TIMEOUT_TICKS, {32'd0, ticks});
    endtask

    task automatic check_report(out_item_t got);
        out_item_t want;
        if (pending_reports.size() == 0)
        begin
            $error("unexpected status beat: wait_status %0d bytes_held %0d",
                   got.wait_status, got.bytes_held);
            mismatch_count++;
            return;
        end
        want = pending_reports.pop_front();
        if (got.wait_status !== want.wait_status)
        begin
            $error("wait_status: expected %0d, actual %0d", want.wait_status,
                   got.wait_status);
            mismatch_count++;
        end
        if (got.bytes_held !== want.bytes_held)
        begin
            $error("bytes_held: expected %0d, actual %0d", want.bytes_held,
                   got.bytes_held);
            mismatch_count++;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when a test asks for one
    initial
    begin
        pop        = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                pop = 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                pop = 1'b0;
                stall_left--;
            end
            else if (!steady && $urandom_range(0, 99) < 25)
            begin
                pop        = 1'b0;
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(10, 60);
            end
            else
                pop = 1'b1;
            @(posedge clk);
            if (pop && !empty)
                check_report(report);
        end
    end

    // Runs of the whole keyword, sometimes with one byte spoiled
    task automatic send_keyword(bit spoil);
        int n;
        int bad;
        logic [7:0] b;
        n   = active_len();
        bad = (n > 0) ? $urandom_range(0, n - 1) : 0;
        for (int j = 0; j < n; j++)
        begin
            b = kw_byte(j);
            if (spoil && j == bad)
                b = b ^ (8'h01 << $urandom_range(0, 7));
            send_item(OP_BYTE, b);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = active_len();
        if (r < 50 && n > 0)
            return kw_byte($urandom_range(0, n - 1));
        if (r < 55)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic randomize_settings();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        logic [31:0] ticks;
        int          r;
        int          pos;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        // now and then a zero byte that cuts the keyword short
        if ($urandom_range(0, 9) == 0)
        begin
            pos = $urandom_range(0, 15);
            if (pos < 8)
                lo[8 * pos +: 8] = 8'h00;
            else
                hi[8 * (pos - 8) +: 8] = 8'h00;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
            len = 5'd0;
        else if (r < 70)
            len = 5'($urandom_range(1, 6));
        else if (r < 85)
            len = 5'($urandom_range(7, 16));
        else
            len = 5'($urandom_range(17, 31));
        r = $urandom_range(0, 99);
        if (r < 7)
            ticks = 32'd0;
        else if (r < 15)
            ticks = 32'hFFFF_FFFF;
        else if (r < 20)
            ticks = $urandom;
        else
            ticks = $urandom_range(1, 40);
        set_keyword(lo, hi, len, ticks);
    endtask

    // Reset values: idle status, empty keyword found at once
    task automatic test_reset_defaults();
        send_item(OP_NOP, 8'h00);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h00);
    endtask

    // Keyword "OK" found after a near miss
    task automatic test_keyword_hit();
        set_keyword(64'h4B4F, 64'h0, 5'd2, TIMEOUT_RESET);
        send_item(OP_START, 8'hA5);
        send_item(OP_BYTE, 8'h4F);
        send_item(OP_BYTE, 8'h58);
        send_item(OP_BYTE, 8'h4F);
        send_item(OP_BYTE, 8'h4B);
        send_item(OP_TICK, 8'h00);
    endtask

    // Bytes after a zero byte are counted but never matched
    task automatic test_text_end();
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h4F);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h4F);
        send_item(OP_BYTE, 8'h4B);
    endtask

    task automatic test_timeouts();
        // zero timeout ends the wait at start
        set_keyword(64'h4B4F, 64'h0, 5'd2, 32'd0);
        send_item(OP_START, 8'h00);
        // one tick allowed
        set_keyword(64'h4B4F, 64'h0, 5'd2, 32'd1);
        send_item(OP_START, 8'h00);
        send_item(OP_TICK, 8'h00);
        // keyword cut short by a zero byte in it
        set_keyword(64'h4142, 64'h0, 5'd16, 32'd5);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h42);
        send_item(OP_BYTE, 8'h41);
    endtask

    // Length above the maximum acts as sixteen; all-ones keyword, longest timeout
    task automatic test_long_keyword();
        set_keyword('1, '1, 5'd31, 32'hFFFF_FFFF);
        send_item(OP_START, 8'h00);
        send_item(OP_TICK, 8'h00);
        repeat (KEY_BYTES) send_item(OP_BYTE, 8'hFF);
    endtask

    // Fill the receive store; the keyword after that is dropped unseen
    task automatic test_store_full();
        set_keyword(64'h4241, 64'h0, 5'd2, 32'hFFFF_FFFF);
        send_item(OP_START, 8'h00);
        repeat (STORE_MAX + 4) send_item(OP_BYTE, 8'($urandom_range(8'h43, 8'hFF)));
        send_item(OP_BYTE, 8'h41);
        send_item(OP_BYTE, 8'h42);
        send_item(OP_TICK, 8'h00);
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h41);
        send_item(OP_BYTE, 8'h42);
    endtask

    // Receiver holds off while beats keep coming, so both queues fill
    task automatic test_backpressure();
        settle();
        steady      = 1'b1;
        hold_cycles = 200;
        repeat (40) send_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        settle();
        steady = 1'b0;
    endtask

    task automatic run_random_phase(int count);
        int first;
        int r;
        first = beats_sent;
        if ($urandom_range(0, 1))
            send_item(OP_START, 8'($urandom_range(0, 255)));
        while (beats_sent - first < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                send_item(OP_START, 8'($urandom_range(0, 255)));
            else if (r < 30)
                send_keyword($urandom_range(0, 4) == 0);
            else if (r < 60)
                send_item(OP_BYTE, pick_byte());
            else if (r < 88)
                send_item(OP_TICK, 8'($urandom_range(0, 255)));
            else
                send_item(OP_NOP, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++)
        begin
            randomize_settings();
            steady = (p == 2);
            run_random_phase(95);
        end
        settle();
        steady = 1'b0;
    endtask

    // Timeout guard
    initial
    begin
        #LIMIT_NS;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        push              = 1'b0;
        rx_item.operation = OP_NOP;
        rx_item.rx_byte   = 8'h00;
        cfg_write         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        kw_low            = '0;
        kw_high           = '0;
        kw_len            = '0;
        tmo_ticks         = TIMEOUT_RESET;
        foreach (recent[k])
            recent[k] = 8'h00;
        held              = 0;
        elapsed           = '0;
        wstate            = ST_IDLE;
        text_done         = 1'b0;
        mismatch_count    = 0;
        beats_sent        = 0;
        hold_cycles       = 0;
        steady            = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_keyword_hit();
        test_text_end();
        test_timeouts();
        test_long_keyword();
        test_store_full();
        test_backpressure();
        test_random();

        settle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/urkw_pkg.sv
src/urkw_queue.sv
src/urkw_front.sv
src/urkw_back.sv
src/uart_response_keyword_wait.sv
tb/testbench.sv
